@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: invariant");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ hdl/dbc_pkg.sv @@
package dbc_pkg;

   typedef enum logic [2:0] {
      K_NORMAL  = 3'd0,
      K_COMMENT = 3'd1,
      K_SQUOTE  = 3'd2,
      K_DQUOTE  = 3'd3,
      K_PAREN   = 3'd4,
      K_BRACKET = 3'd5,
      K_BRACE   = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_END_OK     = 3'd1,
      ST_OVERFLOW   = 3'd2,
      ST_MISMATCH   = 3'd3,
      ST_UNBALANCED = 3'd4
   } status_type;

   localparam logic REQ_CHAR = 1'b0;
   localparam logic REQ_END  = 1'b1;

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;

endpackage

@@ hdl/c_delimiter_balance_checker.sv @@
// channel | ports                                   | direction
// req     | req_valid req_ready req_type req_ch     | in
// rsp     | rsp_valid rsp_ready rsp_status ...      | out
//
// one word per cycle while req_ready is high; each result is registered
// the stack lives in one memory; the top entry sits in registers and the entry below
// it is read every cycle, so a pop the very next cycle already has its new top
// reset clears depth, line count, byte history and error; the memory is not cleared
// req_ready drops only while both the output register and the skid register are full

`include "assert_macros.svh"

module c_delimiter_balance_checker #(
   parameter int STACK_DEPTH = 127,
   parameter int LINE_BITS   = 20
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_type,
   input  logic [7:0]                     req_ch,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output dbc_pkg::status_type            rsp_status,
   output logic [LINE_BITS-1:0]           rsp_report_line,
   output dbc_pkg::kind_type              rsp_expected_kind,
   output dbc_pkg::kind_type              rsp_found_kind,
   output logic [$clog2(STACK_DEPTH)-1:0] rsp_depth
);

   import dbc_pkg::*;

   localparam int DW = $clog2(STACK_DEPTH);
   localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
   localparam logic [DW:0] DEPTH_LIMIT = (DW + 1)'(STACK_DEPTH);

   typedef struct packed {
      kind_type             kind;
      logic [LINE_BITS-1:0] line;
   } entry_type;

   typedef struct packed {
      status_type           status;
      logic [LINE_BITS-1:0] report_line;
      kind_type             expected_kind;
      kind_type             found_kind;
      logic [DW-1:0]        depth;
   } rsp_word_type;

   // stack memory and its registered read port
   entry_type stack_mem [STACK_DEPTH];
   entry_type mem_rd_ff;
   logic [DW-1:0] rd_addr;
   logic          wr_en;

   // state registers
   logic [DW-1:0]        depth_ff, depth_in;
   entry_type            top_ff, top_in;
   logic [LINE_BITS-1:0] line_ff, line_in;
   logic [7:0]           prev_ff, prev_in;
   logic [7:0]           pprev_ff, pprev_in;
   status_type           sticky_ff, sticky_in;

   // output register and skid stage
   rsp_word_type rsp_ff, skid_ff, word_in;
   logic         rsp_valid_ff, skid_valid_ff;

   logic                 req_fire, out_free;
   logic                 esc_ok, is_push, is_pop, push_ovf, pop_bad, push_ok;
   kind_type             op_kind;
   logic [LINE_BITS-1:0] line_nl, line_p1;
   logic [DW:0]          depth_p1;

   assign req_ready = !skid_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // decode the byte against the current top context
   always_comb begin
      esc_ok  = (prev_ff != CH_BSLASH) || (pprev_ff == CH_BSLASH);
      line_nl = (req_ch == CH_NEWLINE && line_ff != LINE_MAX) ? line_ff + 1'b1 : line_ff;
      line_p1 = (line_nl == LINE_MAX) ? LINE_MAX : line_nl + 1'b1;
      is_push = 1'b0;
      is_pop  = 1'b0;
      op_kind = K_NORMAL;
      unique case (top_ff.kind)
         K_COMMENT: begin
            if (prev_ff == CH_STAR && req_ch == CH_SLASH) begin
               is_pop  = 1'b1;
               op_kind = K_COMMENT;
            end
         end
         K_SQUOTE: begin
            if (esc_ok && req_ch == CH_SQUOTE) begin
               is_pop  = 1'b1;
               op_kind = K_SQUOTE;
            end
         end
         K_DQUOTE: begin
            if (esc_ok && req_ch == CH_DQUOTE) begin
               is_pop  = 1'b1;
               op_kind = K_DQUOTE;
            end
         end
         default: begin
            priority if (pprev_ff != CH_BSLASH && prev_ff == CH_SLASH && req_ch == CH_STAR) begin
               is_push = 1'b1;
               op_kind = K_COMMENT;
            end else if (esc_ok) begin
               unique case (req_ch)
                  CH_SQUOTE: begin is_push = 1'b1; op_kind = K_SQUOTE;  end
                  CH_DQUOTE: begin is_push = 1'b1; op_kind = K_DQUOTE;  end
                  CH_LPAREN: begin is_push = 1'b1; op_kind = K_PAREN;   end
                  CH_RPAREN: begin is_pop  = 1'b1; op_kind = K_PAREN;   end
                  CH_LBRACK: begin is_push = 1'b1; op_kind = K_BRACKET; end
                  CH_RBRACK: begin is_pop  = 1'b1; op_kind = K_BRACKET; end
                  CH_LBRACE: begin is_push = 1'b1; op_kind = K_BRACE;   end
                  CH_RBRACE: begin is_pop  = 1'b1; op_kind = K_BRACE;   end
                  default: ;
               endcase
            end
         end
      endcase
      depth_p1 = {1'b0, depth_ff} + (DW + 1)'(1);
      push_ovf = is_push && (depth_p1 >= DEPTH_LIMIT);
      pop_bad  = is_pop && (top_ff.kind != op_kind || depth_ff == '0);
   end

   // next state and result word for the word on req
   always_comb begin
      depth_in  = depth_ff;
      top_in    = top_ff;
      line_in   = line_ff;
      prev_in   = prev_ff;
      pprev_in  = pprev_ff;
      sticky_in = sticky_ff;
      wr_en     = 1'b0;
      push_ok   = 1'b0;
      word_in.status        = ST_OK;
      word_in.report_line   = '0;
      word_in.expected_kind = K_NORMAL;
      priority if (sticky_ff != ST_OK) begin
         word_in.status = sticky_ff;
      end else if (req_type == REQ_END) begin
         if (depth_ff == '0) begin
            word_in.status = ST_END_OK;
         end else begin
            word_in.status        = ST_UNBALANCED;
            word_in.report_line   = top_ff.line;
            word_in.expected_kind = top_ff.kind;
            sticky_in             = ST_UNBALANCED;
         end
      end else begin
         line_in = line_nl;
         priority if (push_ovf) begin
            word_in.status        = ST_OVERFLOW;
            word_in.report_line   = line_nl;
            word_in.expected_kind = op_kind;
            sticky_in             = ST_OVERFLOW;
         end else if (pop_bad) begin
            word_in.status        = ST_MISMATCH;
            word_in.report_line   = line_p1;
            word_in.expected_kind = op_kind;
            sticky_in             = ST_MISMATCH;
         end else begin
            pprev_in = prev_ff;
            prev_in  = req_ch;
            if (is_push) begin
               push_ok     = 1'b1;
               depth_in    = depth_p1[DW-1:0];
               top_in.kind = op_kind;
               top_in.line = line_p1;
               wr_en       = req_fire;
            end else if (is_pop) begin
               depth_in = depth_ff - 1'b1;
               // the bottom entry is always the normal context
               if (depth_ff == DW'(1)) begin
                  top_in.kind = K_NORMAL;
                  top_in.line = '0;
               end else begin
                  top_in = mem_rd_ff;
               end
            end
         end
      end
      word_in.found_kind = top_in.kind;
      word_in.depth      = depth_in;
   end

   // keep the entry under the top on the read port
   always_comb begin
      if (req_fire && !reset) begin
         rd_addr = (depth_in == '0) ? '0 : depth_in - 1'b1;
      end else if (reset || depth_ff == '0) begin
         rd_addr = '0;
      end else begin
         rd_addr = depth_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[depth_in] <= top_in;
      end
      mem_rd_ff <= stack_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= '0;
         top_ff    <= '{kind: K_NORMAL, line: '0};
         line_ff   <= '0;
         prev_ff   <= '0;
         pprev_ff  <= '0;
         sticky_ff <= ST_OK;
      end else if (req_fire) begin
         depth_ff  <= depth_in;
         top_ff    <= top_in;
         line_ff   <= line_in;
         prev_ff   <= prev_in;
         pprev_ff  <= pprev_in;
         sticky_ff <= sticky_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= req_fire;
         end else begin
            rsp_valid_ff <= req_fire;
         end
      end else if (req_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_ff  <= skid_ff;
            skid_ff <= word_in;
         end else begin
            rsp_ff <= word_in;
         end
      end else if (req_fire) begin
         skid_ff <= word_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_report_line   = rsp_ff.report_line;
   assign rsp_expected_kind = rsp_ff.expected_kind;
   assign rsp_found_kind    = rsp_ff.found_kind;
   assign rsp_depth         = rsp_ff.depth;

   `ASSERT_ALWAYS(a_skid_behind_out, clock, reset, !skid_valid_ff || rsp_valid_ff)
   `ASSERT_SAME(a_bottom_normal, clock, reset, depth_ff == '0, top_ff.kind == K_NORMAL)
   `ASSERT_NEXT(a_sticky_freezes, clock, reset, sticky_ff != ST_OK, $stable(depth_ff) && $stable(top_ff) && sticky_ff == $past(sticky_ff))
   // the bottom entry is never stored, so a push from depth zero has nothing to compare
   `ASSERT_NEXT(a_push_depth, clock, reset, req_fire && push_ok && depth_ff != '0, depth_ff == $past(depth_ff) + 1'b1 && mem_rd_ff == $past(top_ff))

endmodule

@@ sim/c_delimiter_balance_checker_tb.sv @@
`timescale 1ns / 1ps

module c_delimiter_balance_checker_tb;
   import dbc_pkg::*;

   localparam int STACK_DEPTH = 127;
   localparam int LINE_BITS = 20;
   localparam logic [LINE_BITS-1:0] LINE_TOP = {LINE_BITS{1'b1}};
   localparam int RANDOM_WORDS = 1250;
   localparam int NEWLINE_FLOOD = 96;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int CYCLE_LIMIT = 100_000;

   typedef struct packed {
      status_type           status;
      logic [LINE_BITS-1:0] line;
      kind_type             exp_kind;
      kind_type             top;
      logic [6:0]           depth;
   } verdict_type;

   typedef struct packed {
      logic     req;
      logic [7:0] ch;
      bit       typed;
      verdict_type want;
   } row_type;

   typedef enum {FIN_OVERFLOW, FIN_MISMATCH, FIN_OPEN_AT_END} error_finale_type;

   localparam verdict_type IDLE_OK = '{ST_OK, '0, K_NORMAL, K_NORMAL, '0};
   localparam verdict_type END_BAL = '{ST_END_OK, '0, K_NORMAL, K_NORMAL, '0};

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic req_type;
   logic [7:0] req_ch;
   logic rsp_valid;
   logic rsp_ready;
   status_type rsp_status;
   logic [LINE_BITS-1:0] rsp_report_line;
   kind_type rsp_expected_kind;
   kind_type rsp_found_kind;
   logic [6:0] rsp_depth;

   // shadow copy of the context stack and scanner state
   kind_type ctx_kind [STACK_DEPTH];
   logic [LINE_BITS-1:0] ctx_line [STACK_DEPTH];
   int unsigned nest;
   logic [LINE_BITS-1:0] line_cnt;
   logic [7:0] last_ch;
   logic [7:0] last2_ch;
   status_type latched;

   verdict_type pending[$];
   int mismatches = 0;
   int cycles = 0;
   int dive = 4;
   bit quiet = 1'b0;
   bit hold_off_request = 1'b0;

   // escapes, quotes, comments and nesting, one word per call
   row_type script [25] = '{
      '{REQ_END,  8'h00,     1'b1, END_BAL},
      '{REQ_CHAR, 8'h00,     1'b1, IDLE_OK},
      '{REQ_CHAR, 8'hFF,     1'b1, IDLE_OK},
      '{REQ_CHAR, CH_LPAREN, 1'b0, IDLE_OK},
      '{REQ_CHAR, CH_LBRACK, 1'b0, IDLE_OK},
      '{REQ_CHAR, CH_LBRACE, 1'b0, IDLE_OK},
      '{REQ_CHAR, CH_BSLASH, 1'b0, IDLE_OK},
      '{REQ_CHAR, CH_LPAREN, 1'b0, IDLE_OK},
      '{REQ_CHAR, CH_SLASH,  1'b0, IDLE_OK},
      '{REQ_CHAR, CH_STAR,   1'b0, IDLE_OK},
      '{REQ_CHAR, CH_STAR,   1'b0, IDLE_OK},
      '{REQ_CHAR, CH_SLASH,  1'b0, IDLE_OK},
      '{REQ_CHAR, CH_DQUOTE, 1'b0, IDLE_OK},
      '{REQ_CHAR, CH_BSLASH, 1'b0, IDLE_OK},
      '{REQ_CHAR, CH_DQUOTE, 1'b0, IDLE_OK},
      '{REQ_CHAR, CH_BSLASH, 1'b0, IDLE_OK},
      '{REQ_CHAR, CH_BSLASH, 1'b0, IDLE_OK},
      '{REQ_CHAR, CH_DQUOTE, 1'b0, IDLE_OK},
      '{REQ_CHAR, CH_SQUOTE, 1'b0, IDLE_OK},
      '{REQ_CHAR, CH_NEWLINE, 1'b0, IDLE_OK},
      '{REQ_CHAR, CH_SQUOTE, 1'b0, IDLE_OK},
      '{REQ_CHAR, CH_RBRACE, 1'b0, IDLE_OK},
      '{REQ_CHAR, CH_RBRACK, 1'b0, IDLE_OK},
      '{REQ_CHAR, CH_RPAREN, 1'b0, IDLE_OK},
      '{REQ_END,  8'hA5,     1'b1, END_BAL}
   };

   c_delimiter_balance_checker i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_ch            (req_ch),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_report_line   (rsp_report_line),
      .rsp_expected_kind (rsp_expected_kind),
      .rsp_found_kind    (rsp_found_kind),
      .rsp_depth         (rsp_depth)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] delim_of(kind_type k, bit closing);
      case (k)
         K_SQUOTE: return CH_SQUOTE;
         K_DQUOTE: return CH_DQUOTE;
         K_PAREN: return closing ? CH_RPAREN : CH_LPAREN;
         K_BRACKET: return closing ? CH_RBRACK : CH_LBRACK;
         K_BRACE: return closing ? CH_RBRACE : CH_LBRACE;
         default: return CH_SLASH;
      endcase
   endfunction

   function automatic kind_type random_nest_kind();
      case ($urandom_range(0, 2))
         0: return K_PAREN;
         1: return K_BRACKET;
         default: return K_BRACE;
      endcase
   endfunction

   function automatic logic [7:0] text_filler();
      case ($urandom_range(0, 9))
         0: return CH_NEWLINE;
         1: return CH_BSLASH;
         2: return 8'h20;
         3: return 8'($urandom_range(0, 255));
         default: return 8'($urandom_range(8'h61, 8'h7A));
      endcase
   endfunction

   // next verdict for one word; state moves only when commit is set
   function automatic verdict_type balance_step(input logic t, input logic [7:0] c,
                                                input bit commit);
      verdict_type v;
      kind_type top;
      kind_type kind;
      logic [LINE_BITS-1:0] lines_n;
      logic [LINE_BITS-1:0] next_line;
      bit opening;
      bit closing;
      bit escaped;
      int unsigned dep;
      v = IDLE_OK;
      top = ctx_kind[nest];
      kind = K_NORMAL;
      opening = 1'b0;
      closing = 1'b0;
      lines_n = line_cnt;
      escaped = last_ch == CH_BSLASH && last2_ch != CH_BSLASH;
      if (latched != ST_OK) begin
         v.status = latched;
      end else if (t == REQ_END) begin
         if (nest == 0) begin
            v.status = ST_END_OK;
         end else begin
            v.status = ST_UNBALANCED;
            v.line = ctx_line[nest];
            v.exp_kind = top;
         end
      end else begin
         if (c == CH_NEWLINE && line_cnt != LINE_TOP) lines_n = line_cnt + 1'b1;
         if (top == K_COMMENT || top == K_SQUOTE || top == K_DQUOTE) begin
            kind = top;
            closing = (top == K_COMMENT) ? (last_ch == CH_STAR && c == CH_SLASH)
                                         : (c == delim_of(top, 1'b1) && !escaped);
         end else if (last2_ch != CH_BSLASH && last_ch == CH_SLASH && c == CH_STAR) begin
            opening = 1'b1;
            kind = K_COMMENT;
         end else if (!escaped) begin
            case (c)
               CH_SQUOTE: begin opening = 1'b1; kind = K_SQUOTE; end
               CH_DQUOTE: begin opening = 1'b1; kind = K_DQUOTE; end
               CH_LPAREN: begin opening = 1'b1; kind = K_PAREN; end
               CH_RPAREN: begin closing = 1'b1; kind = K_PAREN; end
               CH_LBRACK: begin opening = 1'b1; kind = K_BRACKET; end
               CH_RBRACK: begin closing = 1'b1; kind = K_BRACKET; end
               CH_LBRACE: begin opening = 1'b1; kind = K_BRACE; end
               CH_RBRACE: begin closing = 1'b1; kind = K_BRACE; end
               default: ;
            endcase
         end
         next_line = (lines_n == LINE_TOP) ? lines_n : lines_n + 1'b1;
         if (opening && nest + 1 >= STACK_DEPTH) begin
            v.status = ST_OVERFLOW;
            v.line = lines_n;
            v.exp_kind = kind;
         end else if (closing && (top != kind || nest == 0)) begin
            v.status = ST_MISMATCH;
            v.line = next_line;
            v.exp_kind = kind;
         end
      end
      dep = nest;
      if (v.status == ST_OK && opening) dep = nest + 1;
      if (v.status == ST_OK && closing) dep = nest - 1;
      v.depth = 7'(dep);
      v.top = (v.status == ST_OK && opening) ? kind : ctx_kind[dep];
      if (commit) begin
         line_cnt = lines_n;
         if (v.status == ST_OK) begin
            if (opening) begin
               ctx_kind[dep] = kind;
               ctx_line[dep] = next_line;
            end
            last2_ch = last_ch;
            last_ch = c;
         end
         nest = dep;
         if (v.status inside {ST_OVERFLOW, ST_MISMATCH, ST_UNBALANCED}) latched = v.status;
      end
      return v;
   endfunction

   // mostly well formed text; words that would raise an error are drawn again
   task automatic next_random_word(output logic t, output logic [7:0] c, input bit winding);
      verdict_type trial;
      kind_type top;
      int p;
      bit deeper;
      do begin
         t = REQ_CHAR;
         top = ctx_kind[nest];
         p = $urandom_range(0, 99);
         deeper = nest < dive;
         if (!winding && $urandom_range(0, 149) == 0)
            dive = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 126) : $urandom_range(0, 6);
         if (!winding && p < 8) begin
            c = 8'($urandom_range(0, 255));
            if (nest == 0 && p < 3) t = REQ_END;
         end else if (top == K_COMMENT) begin
            if (last_ch == CH_STAR && (winding || p < 70)) c = CH_SLASH;
            else if (winding || p < 35) c = CH_STAR;
            else c = text_filler();
         end else if (top == K_SQUOTE || top == K_DQUOTE) begin
            if (winding || p < 40) c = delim_of(top, 1'b1);
            else if (p < 55) c = CH_BSLASH;
            else c = text_filler();
         end else if (winding) begin
            c = delim_of(top, 1'b1);
         end else if (last_ch == CH_SLASH && p < 60) begin
            c = CH_STAR;
         end else if (p < (deeper ? 70 : 18)) begin
            c = delim_of(random_nest_kind(), 1'b0);
         end else if (nest > 0 && p < (deeper ? 72 : 60)) begin
            c = delim_of(top, 1'b1);
         end else if (p < 80) begin
            case ($urandom_range(0, 2))
               0: c = CH_SQUOTE;
               1: c = CH_DQUOTE;
               default: c = CH_SLASH;
            endcase
         end else begin
            c = text_filler();
         end
         trial = balance_step(t, c, 1'b0);
      end while (trial.status inside {ST_OVERFLOW, ST_MISMATCH, ST_UNBALANCED});
   endtask

   // offer one word, wait for the handshake, then log its verdict
   task automatic send_word(input logic t, input logic [7:0] c, input bit typed,
                            input verdict_type want);
      verdict_type v;
      while (!quiet && $urandom_range(0, 99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= t;
      req_ch <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      v = balance_step(t, c, 1'b1);
      pending.push_back(typed ? want : v);
   endtask

   function automatic int field_diff(string name, logic [LINE_BITS-1:0] expv,
                                     logic [LINE_BITS-1:0] actv);
      if (actv !== expv) begin
         $display("%0t: %s expected %0d got %0d", $time, name, expv, actv);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : rsp_check
      verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending.size() == 0) begin
            $display("%0t: result word with nothing pending", $time);
            mismatches++;
         end else begin
            want = pending.pop_front();
            mismatches += field_diff("status", LINE_BITS'(want.status),
                                     LINE_BITS'(rsp_status));
            mismatches += field_diff("report_line", want.line, rsp_report_line);
            mismatches += field_diff("expected_kind", LINE_BITS'(want.exp_kind),
                                     LINE_BITS'(rsp_expected_kind));
            mismatches += field_diff("found_kind", LINE_BITS'(want.top),
                                     LINE_BITS'(rsp_found_kind));
            mismatches += field_diff("depth", LINE_BITS'(want.depth), LINE_BITS'(rsp_depth));
         end
      end
   end

   // receiver: random back-pressure, plus one long hold-off on request
   initial begin : rsp_drive
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_ready <= quiet || ($urandom_range(0, 99) >= 32);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      logic t;
      logic [7:0] c;
      kind_type k;
      error_finale_type finale;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_CHAR;
      req_ch = 8'h00;
      nest = 0;
      line_cnt = '0;
      last_ch = 8'h00;
      last2_ch = 8'h00;
      latched = ST_OK;
      ctx_kind[0] = K_NORMAL;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 25; i++)
         send_word(script[i].req, script[i].ch, script[i].typed, script[i].want);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == RANDOM_WORDS / 3) hold_off_request = 1'b1;
         next_random_word(t, c, 1'b0);
         send_word(t, c, 1'b0, IDLE_OK);
      end
      while (nest != 0) begin
         next_random_word(t, c, 1'b1);
         send_word(t, c, 1'b0, IDLE_OK);
      end

      // back-to-back newlines with both sides running freely
      quiet = 1'b1;
      for (int n = 0; n < NEWLINE_FLOOD; n++) send_word(REQ_CHAR, CH_NEWLINE, 1'b0, IDLE_OK);
      quiet = 1'b0;

      // errors are sticky, so only one kind of error closes the run
      finale = error_finale_type'($urandom_range(0, 2));
      case (finale)
         FIN_OVERFLOW: begin
            while (latched == ST_OK)
               send_word(REQ_CHAR, delim_of(random_nest_kind(), 1'b0), 1'b0, IDLE_OK);
         end
         FIN_MISMATCH: begin
            repeat ($urandom_range(0, 6))
               send_word(REQ_CHAR, delim_of(random_nest_kind(), 1'b0), 1'b0, IDLE_OK);
            do k = random_nest_kind(); while (k == ctx_kind[nest]);
            send_word(REQ_CHAR, delim_of(k, 1'b1), 1'b0, IDLE_OK);
         end
         default: begin
            repeat ($urandom_range(1, 6)) begin
               k = ($urandom_range(0, 3) == 0) ? K_DQUOTE : random_nest_kind();
               send_word(REQ_CHAR, delim_of(k, 1'b0), 1'b0, IDLE_OK);
            end
            send_word(REQ_END, 8'($urandom_range(0, 255)), 1'b0, IDLE_OK);
         end
      endcase
      repeat (2) begin
         send_word(REQ_CHAR, delim_of(random_nest_kind(), 1'b1), 1'b0, IDLE_OK);
         send_word(REQ_END, 8'($urandom_range(0, 255)), 1'b0, IDLE_OK);
      end
      req_valid <= 1'b0;

      while (pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
